// ===== src/i2cbts_pkg.sv =====
// Shared types and codes for the I2C byte transaction sequencer.
package i2cbts_pkg;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_REPSTART  = 4'd1;
  localparam logic [3:0] ST_WSLA_ACK  = 4'd2;
  localparam logic [3:0] ST_WSLA_NACK = 4'd3;
  localparam logic [3:0] ST_DATA_ACK  = 4'd4;
  localparam logic [3:0] ST_ARB_LOST  = 4'd6;
  localparam logic [3:0] ST_RSLA_ACK  = 4'd7;
  localparam logic [3:0] ST_RSLA_NACK = 4'd8;
  localparam logic [3:0] ST_RX_NACK   = 4'd9;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RECV  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  localparam logic [1:0] CFG_DEVICE_ID    = 2'd0;
  localparam logic [1:0] CFG_SUB_ADDRESS  = 2'd1;
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd2;

  localparam logic [7:0] DEVICE_ID_RST    = 8'd160;
  localparam logic [2:0] SUB_ADDRESS_RST  = 3'd0;
  localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd50;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // fin: entry expands to a stop, then a completion carrying success/read_result
  typedef struct packed {
    logic       fin;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       done_res;
    logic       success;
    logic [7:0] read_result;
  } entry_t;

endpackage

// ===== src/i2c_byte_transaction_sequencer.sv =====
// Top level of the I2C single-byte register read/write sequencer.
// One item is accepted every cycle while full is low: the front end updates the
// transaction state and classifies the item in that cycle, and each item that
// causes results puts one entry into a four-entry queue. The back end hands out
// one result per cycle from the queue head while pop is high; an item that ends
// a transaction with a stop gives two results over two pops (stop, then
// completion) from a single entry, which holds its slot until the completion is
// popped. full rises when four entries of any kind are waiting. Requests while
// busy, status reports while idle and action 3 are taken but cause no result.
module i2c_byte_transaction_sequencer import i2cbts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic [3:0] bus_status,
  input  logic [7:0] received_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] command,
  output logic [7:0] tx_byte,
  output logic       done_res,
  output logic       success,
  output logic [7:0] read_result,
  output logic       last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic   accept;
  logic   gen;
  entry_t entry;
  entry_t head;
  logic   q_empty, q_full, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  i2cbts_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .action        (action),
    .word_address  (word_address),
    .write_data    (write_data),
    .bus_status    (bus_status),
    .received_byte (received_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .gen           (gen),
    .entry         (entry)
  );

  i2cbts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && gen),
    .wdata   (entry),
    .rd      (q_pop),
    .head    (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  i2cbts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .command     (command),
    .tx_byte     (tx_byte),
    .done_res    (done_res),
    .success     (success),
    .read_result (read_result),
    .last        (last)
  );

endmodule

// ===== src/i2cbts_front.sv =====
// Front end: configuration, transaction state and classification of each item.
module i2cbts_front import i2cbts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] action,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic [3:0] bus_status,
  input  logic [7:0] received_byte,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       gen,
  output entry_t     entry
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_SLAW   = 3'd2;
  localparam logic [2:0] PH_WADDR  = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_RSTART = 3'd5;
  localparam logic [2:0] PH_SLAR   = 3'd6;
  localparam logic [2:0] PH_RX     = 3'd7;

  logic [7:0] device_id;
  logic [2:0] sub_address;
  logic [7:0] max_attempts;

  logic [2:0] phase, phase_next;
  logic       is_read, is_read_next;
  logic [7:0] attempt_count, attempt_count_next;
  logic [7:0] saved_wa, saved_wa_next;
  logic [7:0] saved_wd, saved_wd_next;

  logic       do_try, do_fin, fin_ok;
  logic [7:0] att_base;
  logic [7:0] fin_rd;

  always_comb begin
    phase_next         = phase;
    is_read_next       = is_read;
    attempt_count_next = attempt_count;
    saved_wa_next      = saved_wa;
    saved_wd_next      = saved_wd;
    do_try             = 1'b0;
    do_fin             = 1'b0;
    fin_ok             = 1'b0;
    fin_rd             = 8'd0;
    att_base           = attempt_count;
    gen                = 1'b0;
    entry              = '0;

    if ((action == ACT_WRITE) || (action == ACT_READ)) begin
      if (phase == PH_IDLE) begin
        is_read_next  = action[0];
        saved_wa_next = word_address;
        saved_wd_next = write_data;
        att_base      = 8'd0;
        do_try        = 1'b1;
      end
    end else if (action == ACT_STATUS) begin
      unique case (phase)
        PH_IDLE: ;
        PH_START, PH_RSTART: begin
          if (bus_status == ST_ARB_LOST) begin
            do_try = 1'b1;
          end else if ((bus_status == ST_START) || (bus_status == ST_REPSTART)) begin
            gen           = 1'b1;
            entry.command = CMD_SEND;
            entry.tx_byte = {device_id[7:4], sub_address, phase == PH_RSTART};
            phase_next    = (phase == PH_RSTART) ? PH_SLAR : PH_SLAW;
          end else begin
            do_fin = 1'b1;
          end
        end
        PH_SLAW: begin
          if ((bus_status == ST_WSLA_NACK) || (bus_status == ST_ARB_LOST)) begin
            do_try = 1'b1;
          end else if (bus_status == ST_WSLA_ACK) begin
            gen           = 1'b1;
            entry.command = CMD_SEND;
            entry.tx_byte = saved_wa;
            phase_next    = PH_WADDR;
          end else begin
            do_fin = 1'b1;
          end
        end
        PH_WADDR: begin
          if (bus_status != ST_DATA_ACK) begin
            do_fin = 1'b1;
          end else if (is_read) begin
            gen           = 1'b1;
            entry.command = CMD_START;
            phase_next    = PH_RSTART;
          end else begin
            gen           = 1'b1;
            entry.command = CMD_SEND;
            entry.tx_byte = saved_wd;
            phase_next    = PH_DATA;
          end
        end
        PH_DATA: begin
          do_fin = 1'b1;
          fin_ok = (bus_status == ST_DATA_ACK);
        end
        PH_SLAR: begin
          if ((bus_status == ST_RSLA_NACK) || (bus_status == ST_ARB_LOST)) begin
            do_try = 1'b1;
          end else if (bus_status == ST_RSLA_ACK) begin
            gen           = 1'b1;
            entry.command = CMD_RECV;
            phase_next    = PH_RX;
          end else begin
            do_fin = 1'b1;
          end
        end
        PH_RX: begin
          do_fin = 1'b1;
          fin_ok = (bus_status == ST_RX_NACK);
          fin_rd = received_byte;
        end
        default: ;
      endcase
    end

    if (do_try) begin
      gen = 1'b1;
      if (att_base >= max_attempts) begin
        // attempt limit: fail without a stop
        phase_next     = PH_IDLE;
        entry.command  = CMD_NONE;
        entry.done_res = 1'b1;
      end else begin
        attempt_count_next = att_base + 8'd1;
        phase_next         = PH_START;
        entry.command      = CMD_START;
      end
    end else if (do_fin) begin
      gen               = 1'b1;
      phase_next        = PH_IDLE;
      entry.fin         = 1'b1;
      entry.done_res    = 1'b1;
      entry.success     = fin_ok;
      entry.read_result = fin_ok ? fin_rd : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id     <= DEVICE_ID_RST;
      sub_address   <= SUB_ADDRESS_RST;
      max_attempts  <= MAX_ATTEMPTS_RST;
      phase         <= PH_IDLE;
      is_read       <= 1'b0;
      attempt_count <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVICE_ID:    device_id    <= cfg_data;
          CFG_SUB_ADDRESS:  sub_address  <= cfg_data[2:0];
          CFG_MAX_ATTEMPTS: max_attempts <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        is_read       <= is_read_next;
        attempt_count <= attempt_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved_wa <= saved_wa_next;
      saved_wd <= saved_wd_next;
    end
  end

endmodule

// ===== src/i2cbts_queue.sv =====
// Small FIFO of classified entries between front and back.
module i2cbts_queue import i2cbts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wdata,
  input  logic   rd,
  output entry_t head,
  output logic   q_empty,
  output logic   q_full
);

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign q_empty = (count == '0);
  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/i2cbts_back.sv =====
// Back end: expands queued entries into result items, stop before completion.
module i2cbts_back import i2cbts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] command,
  output logic [7:0] tx_byte,
  output logic       done_res,
  output logic       success,
  output logic [7:0] read_result,
  output logic       last
);

  logic second;   // stop of a finishing entry already delivered
  logic stop_now;

  assign empty    = q_empty;
  assign stop_now = head.fin && !second;
  assign q_pop    = pop && !q_empty && !stop_now;

  always_comb begin
    if (stop_now) begin
      command     = CMD_STOP;
      tx_byte     = 8'd0;
      done_res    = 1'b0;
      success     = 1'b0;
      read_result = 8'd0;
      last        = 1'b0;
    end else begin
      command     = head.command;
      tx_byte     = head.tx_byte;
      done_res    = head.done_res;
      success     = head.success;
      read_result = head.read_result;
      last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (pop && !q_empty) begin
      second <= stop_now;
    end
  end

endmodule

// ===== src/i2cbts_checker.sv =====
// Port-level checks for the sequencer, bound to the top level.
module i2cbts_checker import i2cbts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] command,
  input logic       done_res,
  input logic       last
);

  a_rst_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not empty after reset");

  a_done_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> ((command == CMD_NONE) && last))
    else $error("completion item carries a command or is not last");

  a_stop_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (command == CMD_STOP)) |-> (!last && !done_res))
    else $error("stop item marked last or done");

  a_stop_then_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && (command == CMD_STOP)) |=> (!empty && done_res))
    else $error("stop not followed by completion item");

endmodule

bind i2c_byte_transaction_sequencer i2cbts_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .command  (command),
  .done_res (done_res),
  .last     (last)
);

// ===== dv/i2c_byte_transaction_sequencer_tb.sv =====
// Self-checking testbench for the I2C byte transaction sequencer: directed and random items.
module i2c_byte_transaction_sequencer_tb;
  import i2cbts_pkg::*;

  localparam logic [1:0] ACT_NOP      = 2'd3;
  localparam logic [3:0] ST_DATA_NACK = 4'd5;
  localparam logic [3:0] ST_RX_ACK    = 4'd10;
  localparam logic [3:0] ST_OTHER     = 4'd15;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_SLAW, PH_WADDR, PH_DATA, PH_RSTART, PH_SLAR, PH_RX
  } seq_phase_e;

  typedef struct {
    logic [1:0] action;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic [3:0] bus_status;
    logic [7:0] received_byte;
  } stim_t;

  typedef struct {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       done_res;
    logic       success;
    logic [7:0] read_result;
    logic       last;
  } res_t;

  // Tracks the transaction sequence and holds the results still owed by the block.
  class i2c_txn_tracker;
    logic [7:0] device_id;
    logic [2:0] sub_address;
    logic [7:0] max_attempts;
    seq_phase_e phase;
    logic       is_read;
    logic [7:0] attempts;
    logic [7:0] saved_wa;
    logic [7:0] saved_wd;
    logic [7:0] captured;
    res_t       due_results[$];
    int errors, n_checked, n_requests, n_ok, n_bad, n_gave_up, n_settings;

    function new();
      device_id    = DEVICE_ID_RST;
      sub_address  = SUB_ADDRESS_RST;
      max_attempts = MAX_ATTEMPTS_RST;
      phase    = PH_IDLE;
      is_read  = 1'b0;
      attempts = '0;
      saved_wa = '0;
      saved_wd = '0;
      captured = '0;
    endfunction

    function void configure(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_DEVICE_ID:    device_id = val;
        CFG_SUB_ADDRESS:  sub_address = val[2:0];
        CFG_MAX_ATTEMPTS: max_attempts = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] addr(logic rw);
      return {device_id[7:4], sub_address, rw};
    endfunction

    function void emit(logic [2:0] cmd, logic [7:0] tx, logic done, logic ok, logic [7:0] rd);
      res_t r;
      r.command     = cmd;
      r.tx_byte     = tx;
      r.done_res    = done;
      r.success     = ok;
      r.read_result = rd;
      r.last        = 1'b0;
      due_results.push_back(r);
    endfunction

    // new start, or give up without a stop once the attempt budget is spent
    function void retry();
      if (attempts >= max_attempts) begin
        phase = PH_IDLE;
        n_gave_up++;
        emit(CMD_NONE, 8'h00, 1'b1, 1'b0, 8'h00);
      end else begin
        attempts = attempts + 8'd1;
        phase = PH_START;
        emit(CMD_START, 8'h00, 1'b0, 1'b0, 8'h00);
      end
    endfunction

    function void close(logic ok);
      phase = PH_IDLE;
      if (ok) n_ok++;
      else n_bad++;
      emit(CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00);
      emit(CMD_NONE, 8'h00, 1'b1, ok, (ok && is_read) ? captured : 8'h00);
    endfunction

    function void send(seq_phase_e nxt, logic [7:0] b);
      phase = nxt;
      emit(CMD_SEND, b, 1'b0, 1'b0, 8'h00);
    endfunction

    function void on_status(logic [3:0] st, logic [7:0] rx);
      case (phase)
        PH_START, PH_RSTART: begin
          if (st == ST_ARB_LOST) retry();
          else if (st == ST_START || st == ST_REPSTART) begin
            if (phase == PH_START) send(PH_SLAW, addr(1'b0));
            else send(PH_SLAR, addr(1'b1));
          end else close(1'b0);
        end
        PH_SLAW: begin
          if (st == ST_WSLA_NACK || st == ST_ARB_LOST) retry();
          else if (st == ST_WSLA_ACK) send(PH_WADDR, saved_wa);
          else close(1'b0);
        end
        PH_WADDR: begin
          if (st != ST_DATA_ACK) close(1'b0);
          else if (is_read) begin
            // repeated start: not an attempt
            phase = PH_RSTART;
            emit(CMD_START, 8'h00, 1'b0, 1'b0, 8'h00);
          end else send(PH_DATA, saved_wd);
        end
        PH_DATA: close(st == ST_DATA_ACK);
        PH_SLAR: begin
          if (st == ST_RSLA_NACK || st == ST_ARB_LOST) retry();
          else if (st == ST_RSLA_ACK) begin
            phase = PH_RX;
            emit(CMD_RECV, 8'h00, 1'b0, 1'b0, 8'h00);
          end else close(1'b0);
        end
        PH_RX: begin
          if (st == ST_RX_NACK) begin
            captured = rx;
            close(1'b1);
          end else close(1'b0);
        end
        default: ;
      endcase
    endfunction

    // returns the number of results this item owes
    function int take_item(stim_t s);
      int before_n;
      before_n = due_results.size();
      case (s.action)
        ACT_WRITE, ACT_READ: begin
          if (phase == PH_IDLE) begin
            is_read  = (s.action == ACT_READ);
            saved_wa = s.word_address;
            saved_wd = s.write_data;
            attempts = '0;
            n_requests++;
            retry();
          end
        end
        ACT_STATUS: on_status(s.bus_status, s.received_byte);
        default: ;
      endcase
      if (due_results.size() > before_n) due_results[due_results.size() - 1].last = 1'b1;
      return due_results.size() - before_n;
    endfunction

    function void match_result(res_t got);
      res_t want;
      n_checked++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: command %0d tx_byte %02h done_res %0b", $time,
                 got.command, got.tx_byte, got.done_res);
        return;
      end
      want = due_results.pop_front();
      if (got.command !== want.command) begin
        errors++;
        $display("%0t: command expected %0d, got %0d", $time, want.command, got.command);
      end
      if (got.tx_byte !== want.tx_byte) begin
        errors++;
        $display("%0t: tx_byte expected %02h, got %02h", $time, want.tx_byte, got.tx_byte);
      end
      if (got.done_res !== want.done_res) begin
        errors++;
        $display("%0t: done_res expected %0b, got %0b", $time, want.done_res, got.done_res);
      end
      if (got.success !== want.success) begin
        errors++;
        $display("%0t: success expected %0b, got %0b", $time, want.success, got.success);
      end
      if (got.read_result !== want.read_result) begin
        errors++;
        $display("%0t: read_result expected %02h, got %02h", $time, want.read_result,
                 got.read_result);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] action;
  logic [7:0] word_address;
  logic [7:0] write_data;
  logic [3:0] bus_status;
  logic [7:0] received_byte;
  logic       empty;
  logic       pop;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       done_res;
  logic       success;
  logic [7:0] read_result;
  logic       last;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  i2c_txn_tracker board;
  bit no_idle = 1'b0;
  int n_sent = 0;
  int cycles = 0;
  int full_stalls = 0;

  i2c_byte_transaction_sequencer dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (push && full === 1'b1) full_stalls <= full_stalls + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("i2c_byte_transaction_sequencer test failed");
      $finish;
    end
  end

  // mostly a request while idle; else mostly a status that fits the current phase, noise otherwise
  function automatic stim_t pick_item();
    stim_t s;
    int r;
    logic [3:0] good, bad;
    s.action        = ACT_STATUS;
    s.word_address  = 8'($urandom_range(0, 255));
    s.write_data    = 8'($urandom_range(0, 255));
    s.received_byte = 8'($urandom_range(0, 255));
    s.bus_status    = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    good = ST_START;
    bad  = ST_ARB_LOST;
    case (board.phase)
      PH_START, PH_RSTART: good = ($urandom_range(0, 1) != 0) ? ST_REPSTART : ST_START;
      PH_SLAW: begin
        good = ST_WSLA_ACK;
        bad  = ($urandom_range(0, 1) != 0) ? ST_WSLA_NACK : ST_ARB_LOST;
      end
      PH_WADDR, PH_DATA: begin
        good = ST_DATA_ACK;
        bad  = ST_DATA_NACK;
      end
      PH_SLAR: begin
        good = ST_RSLA_ACK;
        bad  = ($urandom_range(0, 1) != 0) ? ST_RSLA_NACK : ST_ARB_LOST;
      end
      PH_RX: begin
        good = ST_RX_NACK;
        bad  = ST_RX_ACK;
      end
      default: ;
    endcase
    if (board.phase == PH_IDLE) begin
      if (r < 86) s.action = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
      else if (r >= 95) s.action = ACT_NOP;
    end else if (r < 4) begin
      s.action = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
    end else if (r < 7) begin
      s.action = ACT_NOP;
    end else if (r >= 25) begin
      s.bus_status = good;
    end else if (r >= 15) begin
      s.bus_status = bad;
    end
    return s;
  endfunction

  task automatic push_item(input stim_t s, output int n);
    push          <= 1'b1;
    action        <= s.action;
    word_address  <= s.word_address;
    write_data    <= s.write_data;
    bus_status    <= s.bus_status;
    received_byte <= s.received_byte;
    do @(posedge clk); while (full !== 1'b0);
    n = board.take_item(s);
    n_sent++;
    if (!no_idle && ((n_sent / 64) % 2 == 0) && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drive(input logic [1:0] act, input logic [3:0] st, input logic [7:0] wa,
                       input logic [7:0] wd, input logic [7:0] rx);
    stim_t s;
    int n;
    s.action        = act;
    s.bus_status    = st;
    s.word_address  = wa;
    s.write_data    = wd;
    s.received_byte = rx;
    push_item(s, n);
  endtask

  task automatic run_random(input int want);
    int got, n;
    got = 0;
    while (got < want) begin
      push_item(pick_item(), n);
      got += n;
    end
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    push <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic [7:0] dev, input logic [7:0] sub, input logic [7:0] lim);
    logic [1:0] idx[3];
    logic [7:0] val[3];
    idx = '{CFG_DEVICE_ID, CFG_SUB_ADDRESS, CFG_MAX_ATTEMPTS};
    val = '{dev, sub, lim};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      board.configure(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    board.n_settings++;
  endtask

  // result side: random pop gaps, plus two long hold-offs that back up the queue
  initial begin
    int hold;
    int gap;
    res_t got;
    hold = 0;
    gap  = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && empty === 1'b0) begin
        got.command     = command;
        got.tx_byte     = tx_byte;
        got.done_res    = done_res;
        got.success     = success;
        got.read_result = read_result;
        got.last        = last;
        board.match_result(got);
        if (board.n_checked == 200 || board.n_checked == 900) hold = 60;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!no_idle && ((board.n_checked / 50) % 2 == 0) &&
                   $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    board = new();
    board.n_settings = 1;
    rst           <= 1'b1;
    push          <= 1'b0;
    action        <= ACT_WRITE;
    word_address  <= 8'h00;
    write_data    <= 8'h00;
    bus_status    <= ST_START;
    received_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_DEVICE_ID;
    cfg_data      <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ignored items while idle
    drive(ACT_STATUS, ST_START, 8'h12, 8'h34, 8'h56);
    drive(ACT_NOP, ST_OTHER, 8'hFF, 8'hFF, 8'hFF);
    // clean write, with a request arriving mid-transaction
    drive(ACT_WRITE, ST_START, 8'hFF, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_START, 8'h00, 8'h00, 8'h00);
    drive(ACT_READ, ST_START, 8'h55, 8'hAA, 8'h00);
    drive(ACT_STATUS, ST_WSLA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_DATA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_DATA_ACK, 8'h00, 8'h00, 8'h00);
    // read with arbitration loss and address nack retries
    drive(ACT_READ, ST_START, 8'h00, 8'hFF, 8'h00);
    drive(ACT_STATUS, ST_ARB_LOST, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_REPSTART, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_WSLA_NACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_START, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_WSLA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_DATA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_START, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_RSLA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_RX_NACK, 8'h00, 8'h00, 8'hFF);
    // unexpected status right after start, then a nacked data byte
    drive(ACT_WRITE, ST_START, 8'h81, 8'h7E, 8'h00);
    drive(ACT_STATUS, ST_OTHER, 8'h00, 8'h00, 8'h00);
    drive(ACT_WRITE, ST_START, 8'h3C, 8'hC3, 8'h00);
    drive(ACT_STATUS, ST_START, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_WSLA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_DATA_ACK, 8'h00, 8'h00, 8'h00);
    drive(ACT_STATUS, ST_DATA_NACK, 8'h00, 8'h00, 8'h00);
    drain();

    // single attempt: arbitration loss gives up with no stop
    load_regs(8'hFF, 8'hFF, 8'd1);
    drive(ACT_WRITE, ST_START, 8'hA5, 8'h5A, 8'h00);
    drive(ACT_STATUS, ST_ARB_LOST, 8'h00, 8'h00, 8'h00);
    drain();
    // no attempts allowed: request fails at once
    load_regs(8'h00, 8'h00, 8'd0);
    drive(ACT_READ, ST_START, 8'h0F, 8'hF0, 8'h00);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_regs(DEVICE_ID_RST, {5'd0, SUB_ADDRESS_RST}, MAX_ATTEMPTS_RST);
        1: load_regs(8'hFF, {5'($urandom_range(0, 31)), 3'd7}, 8'd255);
        2: load_regs(8'h00, 8'h00, 8'd1);
        3: load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd2);
        4: load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd3);
        default: load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(4, 255)));
      endcase
      run_random(170);
      drain();
    end

    // back-to-back traffic, no gaps on either side
    no_idle = 1'b1;
    run_random(180);
    drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d items, %0d transactions: %0d ok, %0d failed with stop, %0d out of attempts",
             n_sent, board.n_requests, board.n_ok, board.n_bad, board.n_gave_up);
    $display("Checked %0d results over %0d register settings; input stalled on full %0d cycles",
             board.n_checked, board.n_settings, full_stalls);
    if (board.errors == 0) begin
      $display("i2c_byte_transaction_sequencer test passed");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("i2c_byte_transaction_sequencer test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/i2cbts_pkg.sv
src/i2cbts_front.sv
src/i2cbts_queue.sv
src/i2cbts_back.sv
src/i2c_byte_transaction_sequencer.sv
src/i2cbts_checker.sv
dv/i2c_byte_transaction_sequencer_tb.sv
